[hw/rtl/gld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_pkg
// Shared types and codes of the GIF LZW image decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gld_pkg;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_PUSH  = 2'd1,
    ACT_PULL  = 2'd2
  } gld_action_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_PIXEL     = 3'd1,
    ST_NEED_DATA = 3'd2,
    ST_END       = 3'd3,
    ST_FULL      = 3'd4,
    ST_COMPLETE  = 3'd5,
    ST_BAD_SIZE  = 3'd6
  } gld_status_t;

  localparam logic [1:0] REG_WIDTH      = 2'd0;
  localparam logic [1:0] REG_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_INTERLACED = 2'd2;

  localparam int MinCodeSizeLow  = 2;
  localparam int MinCodeSizeHigh = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_WALK_RD,
    S_POP,
    S_POP_RD,
    S_EMIT
  } gld_state_t;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [1:0]  pass;
  } gld_pos_t;

endpackage

`default_nettype wire

[hw/rtl/gld_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_in_if
// Request channel: action and data byte with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/gld_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_out_if
// Response channel: status, pixel and position with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gld_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  pixel;
  logic [15:0] column;
  logic [15:0] row;

  modport source (output valid, status, pixel, column, row, input ready);
  modport sink   (input valid, status, pixel, column, row, output ready);
endinterface

`default_nettype wire

[hw/rtl/gif_lzw_image_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_image_decoder_unit
// GIF LZW image-data decoder: strips sub-block lengths, unpacks codes, returns
// pixels with their column and row.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per command: begin (data_byte = minimum code size),
//   push (data_byte = raw stream byte, length bytes included) or pull; the
//   unused action code is taken as a pull.
//   rsp returns exactly one beat per request: status, and for a pixel the
//   color index, column and row (interlace mapped when enabled).
//   cfg_we/cfg_index/cfg_data set width, height and interlace; write only
//   while idle.
// Sequence (states from the accepting edge until req.ready is high again,
// rsp free; rsp.valid rises in the same cycle as req.ready):
//   begin, push and pulls answered without decoding go to S_EMIT. A pull
//   that pops a pixel already on the stack runs S_POP, S_POP_RD and S_EMIT.
//   A pull that decodes runs S_DECODE, then S_EMIT on need data or end of
//   data, S_POP onward for a literal first code after a clear, and for any
//   other code S_WALK, then S_WALK_RD and S_WALK per dictionary link (the
//   dictionary read is registered), then S_POP onward; each clear code met
//   repeats S_DECODE. req.ready is low while a command is at work.
// Reset:
//   rst clears all control state; the dictionary and the pixel stack are
//   not cleared, they are only read where written since the last begin.
// Stall:
//   rsp is a registered output; a finished result waits in the sequencer
//   until rsp is free, while req stays open for the next beat once idle.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_image_decoder_unit #(
  parameter int MAX_CODE_BITS   = 12,
  parameter int BIT_BUFFER_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  gld_in_if.sink           req,
  gld_out_if.source        rsp,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import gld_pkg::*;

  localparam int MW = MAX_CODE_BITS;
  localparam int TableSize = 1 << MW;
  localparam int CW = $clog2(BIT_BUFFER_BITS + 1);

  // configuration
  logic [15:0] image_width, image_height;
  logic        interlaced;

  // sequencer and decoder state
  gld_state_t           state, state_next;
  logic [BIT_BUFFER_BITS-1:0] bbuf, bbuf_next;
  logic [CW-1:0]        bcnt, bcnt_next;
  logic [7:0]           sub_left, sub_left_next;
  logic                 f_fresh, f_fresh_next, f_ended, f_ended_next;
  logic                 f_term, f_term_next, f_active, f_active_next;
  logic [3:0]           cs, cs_next, min_cs, min_cs_next;
  logic [MW:0]          nfc, nfc_next;
  logic [7:0]           fc, fc_next;
  logic [MW-1:0]        prev, prev_next, cur_code, cur_code_next, w, w_next;
  logic [MW:0]          stack_count, stack_count_next;
  gld_pos_t             pos, pos_next, pos_adv;
  logic                 finished, finished_next, adv_fin;
  logic [2:0]           res_status, res_status_next;
  logic [7:0]           res_pixel, res_pixel_next;
  logic [15:0]          res_col, res_col_next, res_row, res_row_next;

  // output register
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [7:0]           out_pixel;
  logic [15:0]          out_col, out_row;

  // memories
  logic [MW-1:0] prefix_mem [TableSize];
  logic [7:0]    suffix_mem [TableSize];
  logic [7:0]    stack_mem  [TableSize];
  logic [MW-1:0] prefix_q;
  logic [7:0]    suffix_q, stack_q;
  logic          dict_we, stack_we;
  logic [7:0]    stack_wd;

  // shared decode datapath
  logic [MW-1:0] clr, code_mask, code;
  logic          cs_ok;
  logic [MW:0]   nfc_inc;

  gld_position u_pos (
    .image_width (image_width),
    .image_height(image_height),
    .interlaced  (interlaced),
    .cur         (pos),
    .nxt         (pos_adv),
    .finished    (adv_fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd256;
      image_height <= 16'd256;
      interlaced   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:      image_width  <= cfg_data;
        REG_HEIGHT:     image_height <= cfg_data;
        REG_INTERLACED: interlaced   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // memories: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (dict_we) begin
      prefix_mem[nfc[MW-1:0]] <= prev;
      suffix_mem[nfc[MW-1:0]] <= w[7:0];
    end
    prefix_q <= prefix_mem[w];
    suffix_q <= suffix_mem[w];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_count[MW-1:0]] <= stack_wd;
    stack_q <= stack_mem[stack_count[MW-1:0] - MW'(1)];
  end

  assign clr       = MW'(1) << min_cs;
  assign code_mask = ~({MW{1'b1}} << cs);
  assign code      = bbuf[MW-1:0] & code_mask;
  assign cs_ok     = (cs != 4'd0) && (cs <= 4'(MAX_CODE_BITS));
  assign nfc_inc   = nfc + (MW+1)'(1);

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.pixel  = out_pixel;
  assign rsp.column = out_col;
  assign rsp.row    = out_row;

  always_comb begin
    state_next       = state;
    bbuf_next        = bbuf;
    bcnt_next        = bcnt;
    sub_left_next    = sub_left;
    f_fresh_next     = f_fresh;
    f_ended_next     = f_ended;
    f_term_next      = f_term;
    f_active_next    = f_active;
    cs_next          = cs;
    min_cs_next      = min_cs;
    nfc_next         = nfc;
    fc_next          = fc;
    prev_next        = prev;
    cur_code_next    = cur_code;
    w_next           = w;
    stack_count_next = stack_count;
    pos_next         = pos;
    finished_next    = finished;
    res_status_next  = res_status;
    res_pixel_next   = res_pixel;
    res_col_next     = res_col;
    res_row_next     = res_row;
    dict_we          = 1'b0;
    stack_we         = 1'b0;
    stack_wd         = 8'd0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_status_next = ST_ACCEPTED;
          res_pixel_next  = 8'd0;
          res_col_next    = 16'd0;
          res_row_next    = 16'd0;
          state_next      = S_EMIT;
          case (req.action)
            ACT_BEGIN: begin
              stack_count_next = '0;
              bbuf_next        = '0;
              bcnt_next        = '0;
              sub_left_next    = 8'd0;
              pos_next         = '0;
              finished_next    = 1'b0;
              fc_next          = 8'd0;
              prev_next        = '0;
              f_term_next      = 1'b0;
              f_ended_next     = 1'b0;
              if (req.data_byte < 8'(MinCodeSizeLow) ||
                  req.data_byte > 8'(MinCodeSizeHigh)) begin
                f_active_next   = 1'b0;
                f_fresh_next    = 1'b0;
                res_status_next = ST_BAD_SIZE;
              end else begin
                min_cs_next   = req.data_byte[3:0];
                cs_next       = req.data_byte[3:0] + 4'd1;
                nfc_next      = ((MW+1)'(1) << req.data_byte[3:0]) + (MW+1)'(2);
                f_active_next = 1'b1;
                f_fresh_next  = 1'b1;
              end
            end
            ACT_PUSH: begin
              if (!f_active) begin
                res_status_next = ST_BAD_SIZE;
              end else if (f_term) begin
                // drop bytes after the terminator
              end else if (sub_left == 8'd0) begin
                if (req.data_byte == 8'd0) f_term_next = 1'b1;
                else sub_left_next = req.data_byte;
              end else if (int'(bcnt) + 8 > BIT_BUFFER_BITS) begin
                res_status_next = ST_FULL;
              end else begin
                bbuf_next     = bbuf | (BIT_BUFFER_BITS'(req.data_byte) << bcnt);
                bcnt_next     = bcnt + CW'(8);
                sub_left_next = sub_left - 8'd1;
              end
            end
            default: begin
              // pull, and the unused action code taken as a pull
              if (!f_active) res_status_next = ST_BAD_SIZE;
              else if (finished) res_status_next = ST_COMPLETE;
              else if (stack_count != '0) state_next = S_POP;
              else if (f_ended) res_status_next = ST_END;
              else state_next = S_DECODE;
            end
          endcase
        end
      end

      S_DECODE: begin
        state_next = S_EMIT;
        if (!cs_ok) begin
          res_status_next = ST_END;
        end else if ({1'b0, bcnt} < (CW+1)'(cs)) begin
          res_status_next = f_term ? ST_END : ST_NEED_DATA;
        end else begin
          bbuf_next = bbuf >> cs;
          bcnt_next = bcnt - CW'(cs);
          if (code == clr) begin
            // restart the dictionary and read the next code
            cs_next          = min_cs + 4'd1;
            nfc_next         = {1'b0, clr} + (MW+1)'(2);
            stack_count_next = '0;
            f_fresh_next     = 1'b1;
            state_next       = S_DECODE;
          end else if (code == clr + MW'(1)) begin
            f_ended_next    = 1'b1;
            res_status_next = ST_END;
          end else if (f_fresh) begin
            if (code >= clr) begin
              f_ended_next    = 1'b1;
              res_status_next = ST_END;
            end else begin
              fc_next      = code[7:0];
              prev_next    = code;
              f_fresh_next = 1'b0;
              stack_we     = 1'b1;
              stack_wd     = code[7:0];
              stack_count_next = stack_count + (MW+1)'(1);
              state_next   = S_POP;
            end
          end else if ({1'b0, code} > nfc) begin
            f_ended_next    = 1'b1;
            res_status_next = ST_END;
          end else begin
            cur_code_next = code;
            w_next        = code;
            if ({1'b0, code} == nfc) begin
              // string not yet in the table: first char, then previous
              stack_we = (stack_count < (MW+1)'(TableSize));
              stack_wd = fc;
              if (stack_we) stack_count_next = stack_count + (MW+1)'(1);
              w_next = prev;
            end
            state_next = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (w >= clr) begin
          state_next = S_WALK_RD;
        end else begin
          fc_next  = w[7:0];
          stack_we = (stack_count < (MW+1)'(TableSize));
          stack_wd = w[7:0];
          if (stack_we) stack_count_next = stack_count + (MW+1)'(1);
          if (!nfc[MW]) begin
            dict_we  = 1'b1;
            nfc_next = nfc_inc;
            if (nfc_inc >= ((MW+1)'(1) << cs) && cs < 4'(MAX_CODE_BITS))
              cs_next = cs + 4'd1;
          end
          prev_next  = cur_code;
          state_next = S_POP;
        end
      end

      S_WALK_RD: begin
        stack_we = (stack_count < (MW+1)'(TableSize));
        stack_wd = suffix_q;
        if (stack_we) stack_count_next = stack_count + (MW+1)'(1);
        w_next     = prefix_q;
        state_next = S_WALK;
      end

      S_POP: begin
        stack_count_next = stack_count - (MW+1)'(1);
        state_next       = S_POP_RD;
      end

      S_POP_RD: begin
        res_status_next = ST_PIXEL;
        res_pixel_next  = stack_q;
        res_col_next    = pos.col;
        res_row_next    = pos.row;
        pos_next        = pos_adv;
        if (adv_fin) finished_next = 1'b1;
        state_next      = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bbuf        <= '0;
      bcnt        <= '0;
      sub_left    <= 8'd0;
      f_fresh     <= 1'b0;
      f_ended     <= 1'b0;
      f_term      <= 1'b0;
      f_active    <= 1'b0;
      cs          <= 4'd0;
      min_cs      <= 4'd0;
      nfc         <= '0;
      fc          <= 8'd0;
      prev        <= '0;
      stack_count <= '0;
      pos         <= '0;
      finished    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      bbuf        <= bbuf_next;
      bcnt        <= bcnt_next;
      sub_left    <= sub_left_next;
      f_fresh     <= f_fresh_next;
      f_ended     <= f_ended_next;
      f_term      <= f_term_next;
      f_active    <= f_active_next;
      cs          <= cs_next;
      min_cs      <= min_cs_next;
      nfc         <= nfc_next;
      fc          <= fc_next;
      prev        <= prev_next;
      stack_count <= stack_count_next;
      pos         <= pos_next;
      finished    <= finished_next;
      // hand the result to the output register once it is free
      if (state == S_EMIT && (!out_valid || rsp.ready)) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_code   <= cur_code_next;
    w          <= w_next;
    res_status <= res_status_next;
    res_pixel  <= res_pixel_next;
    res_col    <= res_col_next;
    res_row    <= res_row_next;
    if (state == S_EMIT && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_pixel  <= res_pixel;
      out_col    <= res_col;
      out_row    <= res_row;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gld_position.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_position
// Next pixel position, with the four-pass interlaced row order.
// ----------------------------------------------------------------------------
`default_nettype none

module gld_position (
  input  wire logic [15:0]      image_width,
  input  wire logic [15:0]      image_height,
  input  wire logic             interlaced,
  input  wire gld_pkg::gld_pos_t cur,
  output gld_pkg::gld_pos_t      nxt,
  output logic                   finished
);
  import gld_pkg::*;

  logic [16:0] w;
  logic [16:0] h;
  logic [16:0] r;
  logic [1:0]  p;
  logic        done;

  always_comb begin
    w = (image_width == 16'd0) ? 17'd1 : {1'b0, image_width};
    h = (image_height == 16'd0) ? 17'd1 : {1'b0, image_height};
    nxt = cur;
    finished = 1'b0;
    r = 17'd0;
    p = cur.pass;
    done = 1'b0;
    if ({1'b0, cur.col} + 17'd1 < w) begin
      nxt.col = cur.col + 16'd1;
    end else begin
      nxt.col = 16'd0;
      if (!interlaced) begin
        if ({1'b0, cur.row} + 17'd1 >= h) finished = 1'b1;
        else nxt.row = cur.row + 16'd1;
      end else begin
        r = {1'b0, cur.row} + ((p <= 2'd1) ? 17'd8 : (p == 2'd2 ? 17'd4 : 17'd2));
        // at most three pass changes before the image runs out
        for (int i = 0; i < 4; i++) begin
          if (!done && r >= h) begin
            if (p == 2'd3) begin
              finished = 1'b1;
              done = 1'b1;
            end else begin
              p = p + 2'd1;
              r = (p == 2'd1) ? 17'd4 : (p == 2'd2 ? 17'd2 : 17'd1);
            end
          end
        end
        nxt.pass = p;
        if (!finished) nxt.row = r[15:0];
      end
    end
  end

endmodule

`default_nettype wire
